// ===== design/nwsp_pkg.sv =====
`default_nettype none
package nwsp_pkg;

  localparam int DUTY_BITS_DEF = 13;
  localparam int TIME_W = 40;
  localparam int MIN_W = 11;
  localparam int HOLD_W = 16;
  localparam int FRAC_W = 14;
  localparam int FRAC_SHIFT = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TIME_W-1:0] SYNC_THRESHOLD = 40'd1700000000;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 14'd8192;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_END = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_HOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd4;

  localparam logic [MIN_W-1:0] NIGHT_START_RST = 11'd1110;
  localparam logic [MIN_W-1:0] NIGHT_END_RST = 11'd530;
  localparam logic [HOLD_W-1:0] WAKE_HOLD_RST = 16'd60;
  localparam logic [FRAC_W-1:0] BRIGHTNESS_RST = 14'd4096;

  typedef enum logic [1:0] {
    MODE_ON   = 2'd0,
    MODE_OFF  = 2'd1,
    MODE_WAKE = 2'd2
  } mode_t;

  typedef struct packed {
    logic              enable;
    logic [MIN_W-1:0]  dusk_min;
    logic [MIN_W-1:0]  dawn_min;
    logic [HOLD_W-1:0] wake_hold;
    logic [FRAC_W-1:0] brightness;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] wake_ts;
  } state_t;

endpackage
`default_nettype wire

// ===== design/nwsp_in_if.sv =====
`default_nettype none
interface nwsp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [nwsp_pkg::TIME_W-1:0]   now_seconds;
  logic [nwsp_pkg::MIN_W-1:0]    minute_of_day;

  modport source (output valid, command, now_seconds, minute_of_day, input ready);
  modport sink (input valid, command, now_seconds, minute_of_day, output ready);
endinterface
`default_nettype wire

// ===== design/nwsp_out_if.sv =====
`default_nettype none
interface nwsp_out_if #(
  parameter int DUTY_BITS = nwsp_pkg::DUTY_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 panel_on;
  logic [DUTY_BITS-1:0] backlight_duty;
  logic [1:0]           screen_mode;
  logic                 mode_changed;

  modport source (output valid, panel_on, backlight_duty, screen_mode, mode_changed,
                  input ready);
  modport sink (input valid, panel_on, backlight_duty, screen_mode, mode_changed,
                output ready);
endinterface
`default_nettype wire

// ===== design/nwsp_update.sv =====
`default_nettype none
module nwsp_update #(
  parameter int DUTY_BITS = nwsp_pkg::DUTY_BITS_DEF
) (
  input  wire nwsp_pkg::cfg_t                  cfg,
  input  wire nwsp_pkg::state_t                st,
  input  wire logic                            command,
  input  wire logic [nwsp_pkg::TIME_W-1:0]     now_seconds,
  input  wire logic [nwsp_pkg::MIN_W-1:0]      minute_of_day,
  output nwsp_pkg::state_t                     st_nxt,
  output logic                                 changed,
  output logic [DUTY_BITS-1:0]                 duty
);

  localparam logic [DUTY_BITS-1:0] DMAX = {DUTY_BITS{1'b1}};
  localparam int PROD_W = DUTY_BITS + nwsp_pkg::FRAC_W;

  logic                          night;
  logic                          synced;
  logic                          expired;
  logic [nwsp_pkg::TIME_W-1:0]   diff;
  logic [nwsp_pkg::FRAC_W-1:0]   b_sat;
  logic [nwsp_pkg::FRAC_W-1:0]   b_inv;
  logic [PROD_W-1:0]             prod;
  logic [DUTY_BITS-1:0]          on_duty;

  always_comb begin
    if (cfg.dusk_min > cfg.dawn_min) begin
      night = (minute_of_day >= cfg.dusk_min) || (minute_of_day < cfg.dawn_min);
    end else begin
      night = (minute_of_day >= cfg.dusk_min) && (minute_of_day < cfg.dawn_min);
    end
  end

  assign synced  = now_seconds > nwsp_pkg::SYNC_THRESHOLD;
  assign diff    = now_seconds - st.wake_ts;
  assign expired = !diff[nwsp_pkg::TIME_W-1] &&
                   (diff >= {{(nwsp_pkg::TIME_W-nwsp_pkg::HOLD_W){1'b0}}, cfg.wake_hold});

  always_comb begin
    st_nxt  = st;
    changed = 1'b0;
    if (!command) begin
      if (!cfg.enable || !synced || !night) begin
        if (st.mode != nwsp_pkg::MODE_ON) begin
          st_nxt.mode = nwsp_pkg::MODE_ON;
          changed     = 1'b1;
        end
      end else if (st.mode == nwsp_pkg::MODE_ON) begin
        st_nxt.mode = nwsp_pkg::MODE_OFF;
        changed     = 1'b1;
      end else if (st.mode == nwsp_pkg::MODE_WAKE && expired) begin
        st_nxt.mode = nwsp_pkg::MODE_OFF;
        changed     = 1'b1;
      end
    end else if (cfg.enable && st.mode == nwsp_pkg::MODE_OFF && night) begin
      st_nxt.mode    = nwsp_pkg::MODE_WAKE;
      st_nxt.wake_ts = now_seconds;
      changed        = 1'b1;
    end
  end

  // inverted duty: floor(DMAX * (1 - b)), b saturated at full
  assign b_sat   = (cfg.brightness > nwsp_pkg::FRAC_ONE) ? nwsp_pkg::FRAC_ONE : cfg.brightness;
  assign b_inv   = nwsp_pkg::FRAC_ONE - b_sat;
  assign prod    = PROD_W'(DMAX) * PROD_W'(b_inv);
  assign on_duty = prod[nwsp_pkg::FRAC_SHIFT +: DUTY_BITS];
  assign duty    = (st_nxt.mode == nwsp_pkg::MODE_OFF) ? DMAX : on_duty;

endmodule
`default_nettype wire

// ===== design/night_window_screen_power_fsm.sv =====
`default_nettype none
// Night-window display power controller. Each input beat (tick or touch with
// epoch seconds and minute of day) yields exactly one result beat with the
// panel enable, inverted backlight duty, screen mode and a changed flag. An
// input register feeds one pass of compare/update logic into the result
// register: one beat per cycle while the output is not stalled; an accepted
// beat is held in the input register, then in the result register. A stalled
// result holds the input register; the input backs up once it is full.
// Config registers (cfg_index 0..4) must be written only while idle.
module night_window_screen_power_fsm #(
  parameter int DUTY_BITS = nwsp_pkg::DUTY_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  nwsp_in_if.sink                                  in_chan,
  nwsp_out_if.source                               out_chan,
  input  wire logic                                cfg_we,
  input  wire logic [nwsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [nwsp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  nwsp_pkg::cfg_t                 cfg_r;
  nwsp_pkg::state_t               st_r;
  nwsp_pkg::state_t               st_nxt;

  logic                           s1_v_r;
  logic                           s1_cmd_r;
  logic [nwsp_pkg::TIME_W-1:0]    s1_now_r;
  logic [nwsp_pkg::MIN_W-1:0]     s1_min_r;
  logic                           s1_move;

  logic                           out_v_r;
  logic                           out_panel_r;
  logic [DUTY_BITS-1:0]           out_duty_r;
  logic [1:0]                     out_mode_r;
  logic                           out_chg_r;

  logic                           changed;
  logic [DUTY_BITS-1:0]           duty;

  assign s1_move       = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !s1_v_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= 1'b0;
      cfg_r.dusk_min    <= nwsp_pkg::NIGHT_START_RST;
      cfg_r.dawn_min    <= nwsp_pkg::NIGHT_END_RST;
      cfg_r.wake_hold   <= nwsp_pkg::WAKE_HOLD_RST;
      cfg_r.brightness  <= nwsp_pkg::BRIGHTNESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nwsp_pkg::CFG_ENABLE:      cfg_r.enable      <= cfg_wdata[0];
        nwsp_pkg::CFG_NIGHT_START: cfg_r.dusk_min    <= cfg_wdata[nwsp_pkg::MIN_W-1:0];
        nwsp_pkg::CFG_NIGHT_END:   cfg_r.dawn_min    <= cfg_wdata[nwsp_pkg::MIN_W-1:0];
        nwsp_pkg::CFG_WAKE_HOLD:   cfg_r.wake_hold   <= cfg_wdata[nwsp_pkg::HOLD_W-1:0];
        nwsp_pkg::CFG_BRIGHTNESS:  cfg_r.brightness  <= cfg_wdata[nwsp_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_cmd_r <= in_chan.command;
      s1_now_r <= in_chan.now_seconds;
      s1_min_r <= in_chan.minute_of_day;
    end
  end

  nwsp_update #(
    .DUTY_BITS(DUTY_BITS)
  ) u_update (
    .cfg           (cfg_r),
    .st            (st_r),
    .command       (s1_cmd_r),
    .now_seconds   (s1_now_r),
    .minute_of_day (s1_min_r),
    .st_nxt        (st_nxt),
    .changed       (changed),
    .duty          (duty)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode    <= nwsp_pkg::MODE_ON;
      st_r.wake_ts <= '0;
      out_v_r      <= 1'b0;
    end else begin
      if (s1_move) begin
        st_r    <= st_nxt;
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_panel_r <= (st_nxt.mode != nwsp_pkg::MODE_OFF);
      out_duty_r  <= duty;
      out_mode_r  <= st_nxt.mode;
      out_chg_r   <= changed;
    end
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.panel_on       = out_panel_r;
  assign out_chan.backlight_duty = out_duty_r;
  assign out_chan.screen_mode    = out_mode_r;
  assign out_chan.mode_changed   = out_chg_r;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
module tb;
  import nwsp_pkg::*;

  localparam int DUTY_W = DUTY_BITS_DEF;
  localparam longint unsigned DUTY_MAX = (64'd1 << DUTY_W) - 1;
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_TOUCH = 1'b1;
  localparam int REPORT_LIMIT = 10;
  localparam int BEATS_PER_PHASE = 150;
  localparam int PHASES = 8;
  localparam int PRESSURE_PHASE = 4;
  localparam int PRESSURE_CYCLES = 400;

  typedef struct packed {
    logic              panel_on;
    logic [DUTY_W-1:0] duty;
    logic [1:0]        mode;
    logic              changed;
  } screen_result_t;

  class power_scoreboard;
    cfg_t regs;
    mode_t mode;
    logic [TIME_W-1:0] wake_ts;
    screen_result_t expected_screens[$];
    int unsigned mismatches;

    function new();
      regs.enable = 1'b0;
      regs.dusk_min = NIGHT_START_RST;
      regs.dawn_min = NIGHT_END_RST;
      regs.wake_hold = WAKE_HOLD_RST;
      regs.brightness = BRIGHTNESS_RST;
      mode = MODE_ON;
      wake_ts = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ENABLE: regs.enable = data[0];
        CFG_NIGHT_START: regs.dusk_min = data[MIN_W-1:0];
        CFG_NIGHT_END: regs.dawn_min = data[MIN_W-1:0];
        CFG_WAKE_HOLD: regs.wake_hold = data[HOLD_W-1:0];
        CFG_BRIGHTNESS: regs.brightness = data[FRAC_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_night(logic [MIN_W-1:0] minute);
      if (regs.dusk_min > regs.dawn_min)
        return minute >= regs.dusk_min || minute < regs.dawn_min;
      return minute >= regs.dusk_min && minute < regs.dawn_min;
    endfunction

    // difference is read as signed 40 bit; negative never expires
    function bit hold_elapsed(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] since;
      since = now - wake_ts;
      if (since[TIME_W-1])
        return 1'b0;
      return since >= TIME_W'(regs.wake_hold);
    endfunction

    function logic [DUTY_W-1:0] lit_duty();
      longint unsigned b;
      longint unsigned one;
      one = FRAC_ONE;
      b = regs.brightness;
      if (b > one)
        b = one;
      return DUTY_W'((DUTY_MAX * (one - b)) / one);
    endfunction

    function void note_beat(logic cmd, logic [TIME_W-1:0] now, logic [MIN_W-1:0] minute);
      screen_result_t r;
      bit night;
      bit changed;
      night = is_night(minute);
      changed = 1'b0;
      if (cmd == CMD_TICK) begin
        if (!regs.enable || now <= SYNC_THRESHOLD || !night) begin
          if (mode != MODE_ON) begin
            mode = MODE_ON;
            changed = 1'b1;
          end
        end else if (mode == MODE_ON) begin
          mode = MODE_OFF;
          changed = 1'b1;
        end else if (mode == MODE_WAKE && hold_elapsed(now)) begin
          mode = MODE_OFF;
          changed = 1'b1;
        end
      end else if (regs.enable && mode == MODE_OFF && night) begin
        mode = MODE_WAKE;
        wake_ts = now;
        changed = 1'b1;
      end
      r.panel_on = (mode != MODE_OFF);
      r.duty = (mode == MODE_OFF) ? DUTY_W'(DUTY_MAX) : lit_duty();
      r.mode = mode;
      r.changed = changed;
      expected_screens.push_back(r);
    endfunction

    function void report(string what, screen_result_t want, screen_result_t got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%s: expected panel=%0d duty=%0d mode=%0d chg=%0d, got panel=%0d duty=%0d mode=%0d chg=%0d",
                 what, want.panel_on, want.duty, want.mode, want.changed,
                 got.panel_on, got.duty, got.mode, got.changed);
    endfunction

    function void check_beat(screen_result_t got);
      screen_result_t want;
      if (expected_screens.size() == 0) begin
        report("unexpected result beat", '0, got);
        return;
      end
      want = expected_screens.pop_front();
      if (got !== want)
        report("result mismatch", want, got);
    endfunction

    function int outstanding();
      return expected_screens.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nwsp_in_if in_chan ();
  nwsp_out_if out_chan ();

  night_window_screen_power_fsm u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  power_scoreboard sb;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_hold;
  logic [TIME_W-1:0] epoch_s;

  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (rx_hold != 0) begin
      out_chan.ready = 1'b0;
      rx_hold--;
    end else begin
      out_chan.ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready)
        sb.check_beat({out_chan.panel_on, out_chan.backlight_duty,
                       out_chan.screen_mode, out_chan.mode_changed});
      if (in_chan.valid && in_chan.ready)
        sb.note_beat(in_chan.command, in_chan.now_seconds, in_chan.minute_of_day);
      if (cfg_we)
        sb.write_reg(cfg_index, cfg_wdata);
    end
  end

  task automatic send_beat(logic cmd, logic [TIME_W-1:0] now, logic [MIN_W-1:0] minute);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.command = cmd;
    in_chan.now_seconds = now;
    in_chan.minute_of_day = minute;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // stop offering, then wait for every pending result plus pipeline slack
  task automatic settle();
    in_chan.valid = 1'b0;
    while (sb.outstanding() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_regs(logic en, int start_m, int end_m, int hold, int bright);
    write_reg(CFG_ENABLE, CFG_DATA_W'(en));
    write_reg(CFG_NIGHT_START, CFG_DATA_W'(start_m));
    write_reg(CFG_NIGHT_END, CFG_DATA_W'(end_m));
    write_reg(CFG_WAKE_HOLD, CFG_DATA_W'(hold));
    write_reg(CFG_BRIGHTNESS, CFG_DATA_W'(bright));
  endtask

  task automatic write_spare_regs();
    for (int i = int'(CFG_BRIGHTNESS) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
  endtask

  task automatic shuffle_regs();
    int start_m;
    int end_m;
    int hold;
    int bright;
    case ($urandom_range(3))
      0: begin
        start_m = $urandom_range(720, 1439);
        end_m = $urandom_range(0, 719);
      end
      1: begin
        start_m = $urandom_range(0, 719);
        end_m = $urandom_range(720, 1439);
      end
      2: begin
        start_m = $urandom_range(0, 1439);
        end_m = start_m;
      end
      default: begin
        start_m = $urandom_range(0, (1 << MIN_W) - 1);
        end_m = $urandom_range(0, (1 << MIN_W) - 1);
      end
    endcase
    case ($urandom_range(5))
      0: hold = 0;
      1: hold = (1 << HOLD_W) - 1;
      default: hold = $urandom_range(1, 200);
    endcase
    case ($urandom_range(5))
      0: bright = 0;
      1: bright = FRAC_ONE;
      2: bright = (1 << FRAC_W) - 1;
      default: bright = $urandom_range(0, (1 << FRAC_W) - 1);
    endcase
    load_regs($urandom_range(99) < 85, start_m, end_m, hold, bright);
    if ($urandom_range(1))
      write_spare_regs();
  endtask

  // mostly synced time marching forward near the wake hold, with jumps
  task automatic random_beat();
    int r;
    logic [MIN_W-1:0] minute;
    r = $urandom_range(99);
    if (r < 75)
      epoch_s += TIME_W'($urandom_range(0, int'(sb.regs.wake_hold) + 3));
    else if (r < 83)
      epoch_s -= TIME_W'($urandom_range(1, 50));
    else if (r < 91)
      epoch_s = {8'($urandom_range(255)), 32'($urandom)};
    else
      epoch_s = SYNC_THRESHOLD - 3 + TIME_W'($urandom_range(0, 6));
    if ($urandom_range(99) < 75) begin
      minute = MIN_W'($urandom_range(0, 1439));
      for (int t = 0; t < 16 && !sb.is_night(minute); t++)
        minute = MIN_W'($urandom_range(0, 1439));
    end else begin
      minute = MIN_W'($urandom_range(0, (1 << MIN_W) - 1));
    end
    send_beat(($urandom_range(99) < 35) ? CMD_TOUCH : CMD_TICK, epoch_s, minute);
  endtask

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0] t0;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.command = CMD_TICK;
    in_chan.now_seconds = '0;
    in_chan.minute_of_day = '0;
    out_chan.ready = 1'b0;
    tx_idle_pct = 30;
    rx_stall_pct = 30;
    rx_hold = 0;
    sb = new();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // disabled: tick keeps screen on, touch ignored
    send_beat(CMD_TICK, '0, '0);
    send_beat(CMD_TOUCH, SYNC_THRESHOLD + 5, 11'd1200);
    settle();
    write_reg(CFG_ENABLE, CFG_DATA_W'(1));
    // sync threshold edge, night off, touch without sync, long expiry
    send_beat(CMD_TICK, SYNC_THRESHOLD, 11'd1200);
    send_beat(CMD_TICK, SYNC_THRESHOLD + 1, 11'd1200);
    send_beat(CMD_TOUCH, '0, 11'd1200);
    send_beat(CMD_TICK, SYNC_THRESHOLD + 1, 11'd100);
    t0 = 40'd2000000000;
    send_beat(CMD_TOUCH, t0, 11'd1439);
    send_beat(CMD_TICK, t0 + 59, 11'd0);
    send_beat(CMD_TICK, t0 - 1, 11'd1439);
    send_beat(CMD_TICK, t0 + 60, 11'd529);
    // wake at the top of the time range, then a tick after wraparound that reads as unsynced
    send_beat(CMD_TOUCH, '1, 11'd1110);
    send_beat(CMD_TICK, '1, '1);
    send_beat(CMD_TICK, 40'd59, '1);
    send_beat(CMD_TICK, SYNC_THRESHOLD + 1, 11'd530);
    send_beat(CMD_TOUCH, SYNC_THRESHOLD + 1, 11'd1200);
    settle();
    // plain window, zero hold, brightness above full
    load_regs(1'b1, 100, 200, 0, (1 << FRAC_W) - 1);
    send_beat(CMD_TICK, SYNC_THRESHOLD + 2, 11'd100);
    send_beat(CMD_TOUCH, SYNC_THRESHOLD + 2, 11'd199);
    send_beat(CMD_TICK, SYNC_THRESHOLD + 2, 11'd150);
    send_beat(CMD_TOUCH, SYNC_THRESHOLD + 3, 11'd200);
    settle();
    // disable while off, empty window, dark brightness
    load_regs(1'b0, 700, 700, (1 << HOLD_W) - 1, 0);
    write_spare_regs();
    send_beat(CMD_TOUCH, SYNC_THRESHOLD + 4, 11'd150);
    send_beat(CMD_TICK, SYNC_THRESHOLD + 4, 11'd150);
    settle();
    write_reg(CFG_ENABLE, CFG_DATA_W'(1));
    write_reg(CFG_BRIGHTNESS, CFG_DATA_W'(FRAC_ONE));
    send_beat(CMD_TICK, SYNC_THRESHOLD + 9, 11'd700);

    epoch_s = SYNC_THRESHOLD + TIME_W'($urandom_range(1, 1000));
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      shuffle_regs();
      case (ph % 4)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin tx_idle_pct = 79; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = 79; end
        default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
      endcase
      if (ph == PRESSURE_PHASE)
        rx_hold = PRESSURE_CYCLES;
      repeat (BEATS_PER_PHASE) random_beat();
    end

    settle();
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
